@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition holds at every clock edge
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// trigger implies consequence at the following edge
`define ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, trig, cons)
`endif
`endif

@@ design/pdci_pkg.sv @@
// ----------------------------------------------------------------------------
// pdci_pkg
// Shared constants and types of the pickup/drop cheapest insertion engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pdci_pkg;
    localparam int NODE_BITS      = 6;
    localparam int MAT_ADDR_BITS  = 2 * NODE_BITS;
    localparam int ROUTE_DEPTH    = 32;
    localparam int ROUTE_IDX_BITS = 5;
    localparam int COUNT_BITS     = 6;
    localparam int ORDER_BITS     = 5;
    localparam int TRAVEL_BITS    = 10;
    localparam int ICOST_BITS     = 13;
    localparam int RCOST_BITS     = 20;
    localparam int DEF_TIME_BITS  = 10;
    localparam logic [3:0] CAP_RESET = 4'd2;

    // action codes
    localparam logic [2:0] ACT_WRITE  = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_EVAL   = 3'd3;
    localparam logic [2:0] ACT_INSERT = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_NOFIT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PD,
        ST_SCAN,
        ST_FIN,
        ST_SHIFT,
        ST_PUTD,
        ST_PUTP,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

@@ design/pickup_drop_cheapest_insertion.sv @@
// ----------------------------------------------------------------------------
// pickup_drop_cheapest_insertion
// Travel-time matrix and one route in memories; finds and optionally performs
// the cheapest insertion of an order's pickup and drop nodes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | action in tuser, node data in tdata
//  m_*      | out       | m_tvalid/m_tready  | status in tuser, result in tdata
//  cfg_*    | in        | cfg_valid/cfg_ready| capacity
//
//  write, append, clear: accept, then result register
//  evaluate: scans each route position in steps paced by the single read port
//  of the travel matrix (five reads per position; fewer for a skipped position);
//  insert then reads and rewrites each moved route entry and writes drop and pickup
//  reset clears route length, route cost and capacity (to 2); no memory sweep
//  a result waits in the output register while the next item is worked on
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pickup_drop_cheapest_insertion #(
    parameter int TIME_BITS = pdci_pkg::DEF_TIME_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action
    input  wire logic [2:0]  s_tuser,
    // from_node, to_node, travel, route_node, order
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status
    output logic [1:0]       m_tuser,
    // insert_cost, pickup_slot, drop_slot, route_length, route_cost
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);
    import pdci_pkg::*;

    localparam int CW     = TIME_BITS + 4;
    localparam int TR_EXT = (TIME_BITS > TRAVEL_BITS) ? TIME_BITS : TRAVEL_BITS;

    // input fields
    logic [NODE_BITS-1:0]   in_from, in_to, in_rnode;
    logic [TRAVEL_BITS-1:0] in_travel;
    logic [ORDER_BITS-1:0]  in_order;
    logic [TR_EXT-1:0]      travel_ext;
    assign in_from    = s_tdata[5:0];
    assign in_to      = s_tdata[11:6];
    assign in_travel  = s_tdata[21:12];
    assign in_rnode   = s_tdata[27:22];
    assign in_order   = s_tdata[32:28];
    assign travel_ext = TR_EXT'(in_travel);

    state_t state_reg, state_next;
    logic   accept;

    // control and datapath registers
    logic [2:0]                action_reg, action_next;
    logic [ORDER_BITS-1:0]     order_reg, order_next;
    logic [COUNT_BITS-1:0]     i_reg, i_next;
    logic [3:0]                step_reg, step_next;
    logic signed [COUNT_BITS:0] load_reg, load_next;
    logic [NODE_BITS-1:0]      node_reg, node_next, x_reg, x_next;
    logic [TIME_BITS-1:0]      pd_reg, pd_next, np_reg, np_next, nd_reg, nd_next;
    logic [TIME_BITS-1:0]      cut_reg, cut_next, dx_reg, dx_next, px_reg, px_next;
    logic signed [CW-1:0]      adj_reg, adj_next, pc_reg, pc_next, dc_reg, dc_next;
    logic signed [CW-1:0]      best_reg, best_next, bp_reg, bp_next;
    logic [ROUTE_IDX_BITS-1:0] bps_reg, bps_next, bds_reg, bds_next, bpl_reg, bpl_next;
    logic                      found_reg, found_next, pv_reg, pv_next;
    logic [ROUTE_IDX_BITS-1:0] k_reg, k_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic signed [RCOST_BITS-1:0] cost_reg, cost_next;
    logic [3:0]                cap_reg;
    logic [1:0]                rsts_reg, rsts_next;
    logic [ICOST_BITS-1:0]     ricost_reg, ricost_next;
    logic [ROUTE_IDX_BITS-1:0] rps_reg, rps_next, rds_reg, rds_next;
    logic                      mval_reg;
    logic [1:0]                mstat_reg;
    logic [55:0]               mdata_reg;

    // memories
    logic [TIME_BITS-1:0]      mat_mem [2**MAT_ADDR_BITS];
    logic [TIME_BITS-1:0]      mat_q;
    logic [MAT_ADDR_BITS-1:0]  mat_raddr;
    logic                      mat_we;
    logic [NODE_BITS-1:0]      rt_mem [ROUTE_DEPTH];
    logic [NODE_BITS-1:0]      rt_q, rt_wdata;
    logic [ROUTE_IDX_BITS-1:0] rt_raddr, rt_waddr;
    logic                      rt_we;

    // derived values
    logic [NODE_BITS-1:0]      p_node, d_node, in_p, in_d;
    logic                      nxt;
    logic [COUNT_BITS-1:0]     i_inc;
    logic signed [COUNT_BITS:0] load_upd;
    logic signed [CW-1:0]      cut_m, dx_m, px_m, best_a, bpdc;
    logic signed [RCOST_BITS:0] best_w, cost_sum;

    assign p_node = {order_reg, 1'b0};
    assign d_node = {order_reg, 1'b1};
    assign in_p   = {in_order, 1'b0};
    assign in_d   = {in_order, 1'b1};
    assign i_inc  = i_reg + COUNT_BITS'(1);
    assign nxt    = (i_inc < count_reg);
    assign load_upd = rt_q[0] ? load_reg - (COUNT_BITS+1)'(1) : load_reg + (COUNT_BITS+1)'(1);
    assign cut_m  = nxt ? $signed(CW'(cut_reg)) : '0;
    assign dx_m   = nxt ? $signed(CW'(dx_reg)) : '0;
    assign px_m   = nxt ? $signed(CW'(px_reg)) : '0;
    assign best_a = (!found_reg || best_reg > adj_reg) ? adj_reg : best_reg;
    assign bpdc   = bp_reg + dc_reg;
    assign best_w = (RCOST_BITS+1)'(best_reg);
    assign cost_sum = (RCOST_BITS+1)'(cost_reg) + best_w;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mval_reg;
    assign m_tuser   = mstat_reg;
    assign m_tdata   = mdata_reg;

    // matrix memory
    assign mat_we = accept && (s_tuser == ACT_WRITE);
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[{in_from, in_to}] <= travel_ext[TIME_BITS-1:0];
        end
        mat_q <= mat_mem[mat_raddr];
    end

    // route memory
    always_ff @(posedge clk)
    begin
        if (rt_we)
        begin
            rt_mem[rt_waddr] <= rt_wdata;
        end
        rt_q <= rt_mem[rt_raddr];
    end

    // memory addressing
    always_comb
    begin
        mat_raddr = {p_node, d_node};
        rt_raddr  = i_reg[ROUTE_IDX_BITS-1:0];
        rt_we     = 1'b0;
        rt_waddr  = count_reg[ROUTE_IDX_BITS-1:0];
        rt_wdata  = in_rnode;
        case (state_reg)
            ST_IDLE:
            begin
                mat_raddr = {in_p, in_d};
                rt_we     = accept && (s_tuser == ACT_APPEND) && (count_reg < ROUTE_DEPTH);
            end
            ST_SCAN:
            begin
                // node i shows up at step 2, node i+1 at step 3
                case (step_reg)
                    4'd2:
                    begin
                        mat_raddr = {rt_q, p_node};
                        rt_raddr  = i_inc[ROUTE_IDX_BITS-1:0];
                    end
                    4'd3:    mat_raddr = {node_reg, d_node};
                    4'd4:    mat_raddr = {node_reg, x_reg};
                    4'd5:    mat_raddr = {d_node, x_reg};
                    4'd6:    mat_raddr = {p_node, x_reg};
                    default: rt_raddr  = i_reg[ROUTE_IDX_BITS-1:0];
                endcase
            end
            ST_SHIFT:
            begin
                rt_raddr = k_reg;
                rt_we    = step_reg[0];
                rt_waddr = k_reg + ROUTE_IDX_BITS'(1) + ROUTE_IDX_BITS'(k_reg > bds_reg);
                rt_wdata = rt_q;
            end
            ST_PUTD:
            begin
                rt_we    = 1'b1;
                rt_waddr = bds_reg + ROUTE_IDX_BITS'(2);
                rt_wdata = d_node;
            end
            ST_PUTP:
            begin
                rt_we    = 1'b1;
                rt_waddr = bps_reg + ROUTE_IDX_BITS'(1);
                rt_wdata = p_node;
            end
            default:
            begin
                rt_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((s_tuser == ACT_EVAL || s_tuser == ACT_INSERT)
                        && (count_reg + COUNT_BITS'(2) <= ROUTE_DEPTH))
                        state_next = ST_PD;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_PD:
                state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (step_reg == 4'd0 && i_reg >= count_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
                state_next = (found_reg && action_reg == ACT_INSERT) ? ST_SHIFT : ST_OUT;
            ST_SHIFT:
            begin
                if (!step_reg[0] && k_reg <= bps_reg)
                    state_next = ST_PUTD;
            end
            ST_PUTD:
                state_next = ST_PUTP;
            ST_PUTP:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!mval_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        action_next = action_reg;
        order_next  = order_reg;
        i_next      = i_reg;
        step_next   = step_reg;
        load_next   = load_reg;
        node_next   = node_reg;
        x_next      = x_reg;
        pd_next     = pd_reg;
        np_next     = np_reg;
        nd_next     = nd_reg;
        cut_next    = cut_reg;
        dx_next     = dx_reg;
        px_next     = px_reg;
        adj_next    = adj_reg;
        pc_next     = pc_reg;
        dc_next     = dc_reg;
        best_next   = best_reg;
        bp_next     = bp_reg;
        bps_next    = bps_reg;
        bds_next    = bds_reg;
        bpl_next    = bpl_reg;
        found_next  = found_reg;
        pv_next     = pv_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        cost_next   = cost_reg;
        rsts_next   = rsts_reg;
        ricost_next = ricost_reg;
        rps_next    = rps_reg;
        rds_next    = rds_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = s_tuser;
                    order_next  = in_order;
                    rsts_next   = STS_OK;
                    ricost_next = '0;
                    rps_next    = '0;
                    rds_next    = '0;
                    case (s_tuser)
                        ACT_APPEND:
                        begin
                            if (count_reg < ROUTE_DEPTH)
                                count_next = count_reg + COUNT_BITS'(1);
                            else
                                rsts_next = STS_FULL;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            cost_next  = '0;
                        end
                        ACT_EVAL, ACT_INSERT:
                        begin
                            if (count_reg + COUNT_BITS'(2) > ROUTE_DEPTH)
                                rsts_next = STS_FULL;
                        end
                        default:
                            rsts_next = STS_OK;
                    endcase
                end
            end
            ST_PD:
            begin
                pd_next    = mat_q;
                i_next     = COUNT_BITS'(1);
                step_next  = '0;
                load_next  = '0;
                found_next = 1'b0;
                pv_next    = 1'b0;
                best_next  = '0;
                bp_next    = '0;
                bps_next   = '0;
                bds_next   = '0;
                bpl_next   = '0;
            end
            ST_SCAN:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd2:
                    begin
                        node_next = rt_q;
                        load_next = load_upd;
                        // position at or above capacity is skipped
                        if (load_upd >= $signed({3'b000, cap_reg}))
                        begin
                            pv_next   = 1'b0;
                            i_next    = i_inc;
                            step_next = '0;
                        end
                    end
                    4'd3: begin x_next = rt_q; np_next = mat_q; end
                    4'd4: nd_next  = mat_q;
                    4'd5: cut_next = mat_q;
                    4'd6: dx_next  = mat_q;
                    4'd7: px_next  = mat_q;
                    4'd8:
                    begin
                        adj_next = $signed(CW'(np_reg)) + $signed(CW'(pd_reg)) + dx_m - cut_m;
                        pc_next  = $signed(CW'(np_reg)) + px_m - cut_m;
                        dc_next  = $signed(CW'(nd_reg)) + dx_m - cut_m;
                    end
                    4'd9:
                    begin
                        // side by side, then split, then best pickup so far
                        best_next  = best_a;
                        if (!found_reg || best_reg > adj_reg)
                        begin
                            bps_next = i_reg[ROUTE_IDX_BITS-1:0];
                            bds_next = i_reg[ROUTE_IDX_BITS-1:0];
                        end
                        if (pv_reg && best_a > bpdc)
                        begin
                            best_next = bpdc;
                            bds_next  = i_reg[ROUTE_IDX_BITS-1:0];
                            bps_next  = bpl_reg;
                        end
                        if (!pv_reg || bp_reg > pc_reg)
                        begin
                            bp_next  = pc_reg;
                            bpl_next = i_reg[ROUTE_IDX_BITS-1:0];
                        end
                        pv_next    = 1'b1;
                        found_next = 1'b1;
                        i_next     = i_inc;
                        step_next  = '0;
                    end
                    default:
                        step_next = step_reg + 4'd1;
                endcase
            end
            ST_FIN:
            begin
                step_next = '0;
                k_next    = ROUTE_IDX_BITS'(count_reg - COUNT_BITS'(1));
                if (!found_reg)
                begin
                    rsts_next = STS_NOFIT;
                end
                else
                begin
                    if (best_w > (RCOST_BITS+1)'(4095))
                        ricost_next = ICOST_BITS'(4095);
                    else if (best_w < -(RCOST_BITS+1)'(4096))
                        ricost_next = ICOST_BITS'(-4096);
                    else
                        ricost_next = best_w[ICOST_BITS-1:0];
                    rps_next = bps_reg;
                    rds_next = bds_reg;
                end
            end
            ST_SHIFT:
            begin
                // read entry k, then write it to its shifted place
                step_next = {3'b000, ~step_reg[0]};
                if (step_reg[0])
                    k_next = k_reg - ROUTE_IDX_BITS'(1);
            end
            ST_PUTP:
            begin
                count_next = count_reg + COUNT_BITS'(2);
                if (cost_sum > (RCOST_BITS+1)'(524287))
                    cost_next = RCOST_BITS'(524287);
                else if (cost_sum < -(RCOST_BITS+1)'(524288))
                    cost_next = RCOST_BITS'(-524288);
                else
                    cost_next = cost_sum[RCOST_BITS-1:0];
            end
            default:
                step_next = step_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cost_reg  <= '0;
            cap_reg   <= CAP_RESET;
            mval_reg  <= 1'b0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cost_reg  <= cost_next;
            step_reg  <= step_next;
            found_reg <= found_next;
            pv_reg    <= pv_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (state_reg == ST_OUT && (!mval_reg || m_tready))
                mval_reg <= 1'b1;
            else if (m_tready)
                mval_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        order_reg  <= order_next;
        i_reg      <= i_next;
        load_reg   <= load_next;
        node_reg   <= node_next;
        x_reg      <= x_next;
        pd_reg     <= pd_next;
        np_reg     <= np_next;
        nd_reg     <= nd_next;
        cut_reg    <= cut_next;
        dx_reg     <= dx_next;
        px_reg     <= px_next;
        adj_reg    <= adj_next;
        pc_reg     <= pc_next;
        dc_reg     <= dc_next;
        best_reg   <= best_next;
        bp_reg     <= bp_next;
        bps_reg    <= bps_next;
        bds_reg    <= bds_next;
        bpl_reg    <= bpl_next;
        k_reg      <= k_next;
        rsts_reg   <= rsts_next;
        ricost_reg <= ricost_next;
        rps_reg    <= rps_next;
        rds_reg    <= rds_next;
        if (state_reg == ST_OUT && (!mval_reg || m_tready))
        begin
            mstat_reg <= rsts_reg;
            mdata_reg <= {7'b0, cost_reg, count_reg, rds_reg, rps_reg, ricost_reg};
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= ROUTE_DEPTH)
    `ASSERT_NEXT(a_one_item, accept, !s_tready)
    `ASSERT_ALWAYS(a_slot_order, !found_reg || bps_reg <= bds_reg)
endmodule
`default_nettype wire

@@ sim/pickup_drop_cheapest_insertion_test.sv @@
// ----------------------------------------------------------------------------
// pickup_drop_cheapest_insertion_test
// Self-checking bench for the pickup/drop insertion engine. The travel entries
// among sixteen nodes (0 to 7 and 56 to 63) are loaded first. Every route node
// and every order but the directed order 5 stays within them. Then directed items and random
// route-building sequences run under several capacities. Every result is
// checked field by field against a behavioral predictor kept in step with the
// accepted items.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module pickup_drop_cheapest_insertion_test;
    import pdci_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] icost;
        logic [4:0]  pslot;
        logic [4:0]  dslot;
        logic [5:0]  length;
        logic [19:0] rcost;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    // predictor state
    logic [9:0]  travel_mat [0:4095];
    logic [5:0]  route_q [0:31];
    int          route_len;
    int          route_sum;
    int          cap_now;

    result_t     pending_results [$];
    int          errors;
    int          sent;
    bit          calm;
    int          stall_left;

    pickup_drop_cheapest_insertion DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #60ms;
        $display("[pickup_drop_cheapest_insertion] ERROR");
        $finish;
    end

    function automatic int tt(input int a, input int b);
        return int'(travel_mat[a * 64 + b]);
    endfunction

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // node of the loaded set: 0 to 7 and 56 to 63
    function automatic int node_of(input int n);
        return n < 8 ? n : n + 48;
    endfunction

    function automatic int pick_node();
        return node_of($urandom_range(0, 15));
    endfunction

    // order whose pickup and drop both lie in the loaded set
    function automatic int pick_order();
        int o;
        o = $urandom_range(0, 7);
        return o < 4 ? o : o + 24;
    endfunction

    // work out the result of one item and advance the predicted state
    function automatic result_t predict_item(input logic [2:0] act, input int from_n,
                                             input int to_n, input int trv,
                                             input int rnode, input int order);
        result_t r;
        int p, d, load, best, bp, bps, bds, bpl, node, x, cut, adj, pc, dc, m;
        bit found, pv, nxt;
        logic [5:0] tmp [0:31];
        r = '0;
        if (act == ACT_WRITE)
        begin
            travel_mat[from_n * 64 + to_n] = trv[9:0];
        end
        else if (act == ACT_APPEND)
        begin
            if (route_len < 32)
            begin
                route_q[route_len] = rnode[5:0];
                route_len++;
            end
            else
                r.status = STS_FULL;
        end
        else if (act == ACT_CLEAR)
        begin
            route_len = 0;
            route_sum = 0;
        end
        else if (act == ACT_EVAL || act == ACT_INSERT)
        begin
            if (route_len + 2 > 32)
                r.status = STS_FULL;
            else
            begin
                p = 2 * order;
                d = p + 1;
                load = 0; best = 0; bp = 0; bps = 0; bds = 0; bpl = 0;
                found = 0; pv = 0;
                for (int i = 1; i < route_len; i++)
                begin
                    node = route_q[i];
                    nxt = (i + 1) < route_len;
                    x = nxt ? route_q[i + 1] : 0;
                    cut = nxt ? tt(node, x) : 0;
                    load += node[0] ? -1 : 1;
                    if (load >= cap_now)
                    begin
                        pv = 0;
                        continue;
                    end
                    adj = tt(node, p) + tt(p, d) + (nxt ? tt(d, x) - cut : 0);
                    if (!found || best > adj)
                    begin
                        best = adj; bps = i; bds = i; found = 1;
                    end
                    pc = tt(node, p) + (nxt ? tt(p, x) - cut : 0);
                    dc = tt(node, d) + (nxt ? tt(d, x) - cut : 0);
                    if (pv && best > bp + dc)
                    begin
                        best = bp + dc; bds = i; bps = bpl;
                    end
                    if (!pv || bp > pc)
                    begin
                        bp = pc; bpl = i; pv = 1;
                    end
                end
                if (!found)
                    r.status = STS_NOFIT;
                else
                begin
                    r.icost = 13'(clampi(best, -4096, 4095));
                    r.pslot = bps[4:0];
                    r.dslot = bds[4:0];
                    if (act == ACT_INSERT)
                    begin
                        m = 0;
                        for (int k = 0; k < route_len; k++)
                        begin
                            tmp[m++] = route_q[k];
                            if (k == bps)
                                tmp[m++] = p[5:0];
                            if (k == bds)
                                tmp[m++] = d[5:0];
                        end
                        for (int k = 0; k < m; k++)
                            route_q[k] = tmp[k];
                        route_len = m;
                        route_sum = clampi(route_sum + best, -524288, 524287);
                    end
                end
            end
        end
        r.length = route_len[5:0];
        r.rcost = route_sum[19:0];
        return r;
    endfunction

    // send one item; nogap skips the idle draw
    task automatic send_item(input logic [2:0] act, input int from_n, input int to_n,
                             input int trv, input int rnode, input int order,
                             input bit nogap = 0);
        int gap;
        result_t exp_r;
        gap = (nogap || calm) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, order[4:0], rnode[5:0], trv[9:0], to_n[5:0], from_n[5:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_r = predict_item(act, from_n, to_n, trv, rnode, order);
        pending_results = {pending_results, exp_r};
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input int cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap[3:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_now = cap;
    endtask

    task automatic append_random(input int count);
        for (int k = 0; k < count; k++)
            send_item(ACT_APPEND, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 1023), pick_node(),
                      $urandom_range(0, 31));
    endtask

    // result checker with random back-pressure
    always @(posedge clk)
    begin
        result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[12:0], m_tdata[17:13], m_tdata[22:18],
                   m_tdata[28:23], m_tdata[48:29]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.icost !== want.icost)
                    $display("%0t: insert_cost exp %0d got %0d", $time,
                             $signed(want.icost), $signed(got.icost));
                if (got.pslot !== want.pslot)
                    $display("%0t: pickup_slot exp %0d got %0d", $time, want.pslot, got.pslot);
                if (got.dslot !== want.dslot)
                    $display("%0t: drop_slot exp %0d got %0d", $time, want.dslot, got.dslot);
                if (got.length !== want.length)
                    $display("%0t: route_length exp %0d got %0d", $time,
                             want.length, got.length);
                if (got.rcost !== want.rcost)
                    $display("%0t: route_cost exp %0d got %0d", $time,
                             $signed(want.rcost), $signed(got.rcost));
                if (got !== want)
                    errors++;
            end
            stall_left = calm ? 0 : $urandom_range(0, 17);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // load every entry among the node set so no read that a result depends on hits an unwritten one
    task automatic test_matrix_load();
        calm = 1;
        for (int f = 0; f < 16; f++)
            for (int t = 0; t < 16; t++)
                send_item(ACT_WRITE, node_of(f), node_of(t), $urandom_range(0, 1023),
                          0, 0, 1);
        send_item(ACT_WRITE, 63, 63, 1023, 63, 31, 1);
        send_item(ACT_WRITE, 0, 0, 0, 0, 0, 1);
        calm = 0;
    endtask

    // short routes, full routes, unused actions, extreme orders
    task automatic test_directed();
        send_item(ACT_EVAL, 0, 0, 0, 0, 5);
        send_item(ACT_APPEND, 0, 0, 0, 0, 0);
        send_item(ACT_INSERT, 0, 0, 0, 0, 31);
        send_item(ACT_APPEND, 0, 0, 0, 63, 0);
        send_item(ACT_EVAL, 0, 0, 0, 0, 0);
        send_item(ACT_INSERT, 0, 0, 0, 0, 31);
        send_item(ACT_INSERT, 0, 0, 0, 0, 0);
        send_item(3'd5, 63, 63, 1023, 63, 31);
        send_item(3'd6, 0, 0, 0, 0, 0);
        send_item(3'd7, 21, 42, 682, 21, 10);
        append_random(26);
        send_item(ACT_EVAL, 0, 0, 0, 0, 3);
        send_item(ACT_INSERT, 0, 0, 0, 0, 28);
        send_item(ACT_EVAL, 0, 0, 0, 0, 29);
        append_random(3);
        send_item(ACT_INSERT, 0, 0, 0, 0, 1);
        send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    endtask

    // each capacity extreme, including zero
    task automatic test_capacity_extremes();
        int caps [4] = '{0, 15, 1, 2};
        foreach (caps[c])
        begin
            set_capacity(caps[c]);
            send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
            append_random(6);
            for (int k = 0; k < 4; k++)
                send_item(k[0] ? ACT_EVAL : ACT_INSERT, 0, 0, 0, 0, pick_order());
        end
    endtask

    // random route-building sessions with occasional noise
    task automatic test_random_sessions();
        int pick;
        while (sent < 850)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                set_capacity($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
            append_random($urandom_range(0, 12));
            repeat ($urandom_range(2, 10))
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    send_item(ACT_INSERT, 0, 0, 0, 0, pick_order());
                else if (pick < 13)
                    send_item(ACT_EVAL, 0, 0, 0, 0, pick_order());
                else if (pick < 16)
                    append_random($urandom_range(1, 4));
                else if (pick < 18)
                    send_item(ACT_WRITE, pick_node(), pick_node(),
                              $urandom_range(0, 1023), $urandom_range(0, 63),
                              $urandom_range(0, 31));
                else
                    send_item(3'($urandom_range(5, 7)), $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 1023),
                              $urandom_range(0, 63), $urandom_range(0, 31));
            end
        end
        calm = 0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        route_len  = 0;
        route_sum  = 0;
        cap_now    = 2;
        errors     = 0;
        sent       = 0;
        calm       = 0;
        stall_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_matrix_load();
        test_directed();
        test_capacity_extremes();
        test_random_sessions();

        wait_drained();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("[pickup_drop_cheapest_insertion] OK");
        else
            $display("[pickup_drop_cheapest_insertion] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
